// ===== src/fba_pkg.sv =====
// Shared types and constants for the frame bitmap allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package fba_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAME_W   = 12;
    localparam int CFG_W     = 13;
    localparam int FRAME_FIELD_LIMIT = 4096;
    localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;
    localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 13'h1000;

    // Operation codes carried on s_tuser.
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    // Status codes carried on m_tuser.
    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_HAD_FRAME = 2'd1;
    localparam logic [1:0] STAT_NO_FREE   = 2'd2;
    localparam logic [1:0] STAT_NOTHING   = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_FREE_RMW,
        S_TEST_RD,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_HAD_FRAME,
        RES_NO_FREE,
        RES_NOTHING,
        RES_FREED,
        RES_ALLOC,
        RES_TEST,
        RES_TEST_MISS
    } res_kind_t;

    typedef struct packed {
        logic      capture;
        logic      clear_wr;
        logic      scan_start;
        logic      scan_next;
        logic      read_frame;
        logic      write_alloc;
        logic      write_free;
        logic      res_load;
        res_kind_t res_kind;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic [1:0] op;
        logic       frame_zero;
        logic       frame_oob;
        logic       scan_empty;
        logic       word_full;
        logic       scan_last;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== src/frame_bitmap_allocator_top.sv =====
// First-fit page-frame allocator over a one-bit-per-frame usage bitmap.
// A request on the s_ channel allocates, frees or tests a frame; every
// request returns exactly one result on the m_ channel. After reset the
// bitmap RAM is swept to zero, one word per cycle, over all ceil(MAX_FRAMES/32)
// words (128 at the default), and s_tready stays low until the sweep ends.
// Requests are handled one at a time. An allocate reads the bitmap words in
// order until a word with a free frame turns up, reading 1 to frame_count/32
// words, at most 128; the words are read one at a time through the single
// read port of the bitmap RAM. Free and test of a frame in range read its
// bitmap word; a free then writes it back with the frame's bit cleared
// (read, modify, write). A new request is taken while the previous result
// still waits on the m_ channel; the result register then holds the next
// result until the sink takes the old one. frame_count is written through
// cfg_wr_en/cfg_wr_data and must only change while no request is in flight.
// Depends on fba_pkg, fba_ctrl, fba_datapath and fba_ram.
`timescale 1ns / 1ps

module frame_bitmap_allocator_top #(
    parameter int MAX_FRAMES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration: frame_count
    input  logic                      cfg_wr_en,
    input  logic [fba_pkg::CFG_W-1:0] cfg_wr_data,

    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] entry_frame, [12] kernel_only,
                                   // [13] writable_req, [15:14] zero
    input  logic [1:0]  s_tuser,   // [1:0] operation

    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] frame_out, [12] present, [13] writable,
                                   // [14] user_mode, [15] in_use
    output logic [1:0]  m_tuser    // [1:0] status
);

    import fba_pkg::*;

    localparam int FRAME_CAP = (MAX_FRAMES < FRAME_FIELD_LIMIT) ? MAX_FRAMES
                                                                : FRAME_FIELD_LIMIT;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence the request: dispatch, scan, read-modify-write or read, then hand off.
    fba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold the request, the bitmap and the result registers.
    fba_datapath #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cmd        (cmd),
        .stat       (stat)
    );

    // One request in flight: acceptance drops ready for the next cycle.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // A present entry only comes with a done status.
    a_present_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[12]) |-> (m_tuser == STAT_DONE))
        else $error("present entry with a failure status");

    // An allocated frame lies inside the managed range.
    a_alloc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[12]) |-> ({1'b0, m_tdata[11:0]} < CFG_W'(FRAME_CAP)))
        else $error("allocated frame beyond the managed range");

    // An entry that already had a frame echoes a nonzero frame.
    a_had_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STAT_HAD_FRAME)) |-> (m_tdata[11:0] != 12'd0))
        else $error("already-had-frame status with frame zero");

endmodule

// ===== src/fba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the usage bitmap words.
`timescale 1ns / 1ps

module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/fba_ctrl.sv =====
// Controller state machine for the frame bitmap allocator.
// Depends on fba_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
`timescale 1ns / 1ps

module fba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  fba_pkg::dp_stat_t stat,
    output fba_pkg::dp_cmd_t  cmd
);

    import fba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.res_kind = RES_ZERO;
        s_tready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = S_DONE;
                case (stat.op)
                    OP_ALLOC: begin
                        if (!stat.frame_zero) begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_HAD_FRAME;
                        end else if (stat.scan_empty) begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_NO_FREE;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    OP_FREE: begin
                        if (stat.frame_zero) begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_NOTHING;
                        end else if (stat.frame_oob) begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_FREED;
                        end else begin
                            cmd.read_frame = 1'b1;
                            state_next     = S_FREE_RMW;
                        end
                    end
                    OP_TEST: begin
                        if (stat.frame_oob) begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_TEST_MISS;
                        end else begin
                            cmd.read_frame = 1'b1;
                            state_next     = S_TEST_RD;
                        end
                    end
                    default: begin
                        cmd.res_load = 1'b1;
                        cmd.res_kind = RES_ZERO;
                    end
                endcase
            end
            S_SCAN: begin
                if (!stat.word_full) begin
                    cmd.write_alloc = 1'b1;
                    cmd.res_load    = 1'b1;
                    cmd.res_kind    = RES_ALLOC;
                    state_next      = S_DONE;
                end else if (stat.scan_last) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_NO_FREE;
                    state_next   = S_DONE;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_FREE_RMW: begin
                cmd.write_free = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_kind   = RES_FREED;
                state_next     = S_DONE;
            end
            S_TEST_RD: begin
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_TEST;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/fba_datapath.sv =====
// Datapath of the frame bitmap allocator: request and result registers,
// scan counter, clearing counter, bitmap RAM and output register.
// Depends on fba_pkg and fba_ram.
`timescale 1ns / 1ps

module fba_datapath #(
    parameter int MAX_FRAMES = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [fba_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic [15:0]                  s_tdata,
    input  logic [1:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,
    output logic [1:0]                   m_tuser,
    input  fba_pkg::dp_cmd_t             cmd,
    output fba_pkg::dp_stat_t            stat
);

    import fba_pkg::*;

    localparam int WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FRAME_CAP = (MAX_FRAMES < FRAME_FIELD_LIMIT) ? MAX_FRAMES
                                                                : FRAME_FIELD_LIMIT;
    localparam logic [CFG_W-1:0] FRAME_CAP_V = CFG_W'(FRAME_CAP);
    localparam logic [7:0]       CAP_WORDS_V = 8'(FRAME_CAP / WORD_BITS);
    localparam logic [AW-1:0]    LAST_WORD   = AW'(WORDS - 1);

    // Request registers
    logic [1:0]         op_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic               kern_reg;
    logic               wr_reg;
    logic [CFG_W-1:0]   frame_count_reg;

    logic [7:0]    scan_idx_reg;
    logic [AW-1:0] clr_idx_reg;

    // Result registers and output register
    logic [FRAME_W-1:0] res_frame_reg;
    logic               res_pres_reg;
    logic               res_wr_reg;
    logic               res_user_reg;
    logic [1:0]         res_stat_reg;
    logic               res_used_reg;
    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] wdata;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic                 we;
    logic [4:0]           free_pos;
    logic [7:0]           scan_nxt;
    logic [7:0]           scan_words;
    logic [AW-1:0]        frame_word;

    assign scan_nxt   = scan_idx_reg + 8'd1;
    assign scan_words = (frame_count_reg[CFG_W-1:5] < CAP_WORDS_V) ? frame_count_reg[CFG_W-1:5]
                                                                    : CAP_WORDS_V;
    assign frame_word = AW'(frame_reg[FRAME_W-1:5]);

    always_comb begin
        free_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!rdata[i]) begin
                free_pos = 5'(i);
            end
        end
    end

    // RAM port selection
    always_comb begin
        we    = cmd.clear_wr | cmd.write_alloc | cmd.write_free;
        waddr = clr_idx_reg;
        wdata = '0;
        if (cmd.write_alloc) begin
            waddr = AW'(scan_idx_reg);
            wdata = rdata | (WORD_BITS'(1) << free_pos);
        end else if (cmd.write_free) begin
            waddr = frame_word;
            wdata = rdata & ~(WORD_BITS'(1) << frame_reg[4:0]);
        end
        raddr = '0;
        if (cmd.scan_next) begin
            raddr = AW'(scan_nxt);
        end else if (cmd.read_frame) begin
            raddr = frame_word;
        end
    end

    fba_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(WORDS)
    ) u_bitmap (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= FRAME_COUNT_RESET;
            clr_idx_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                frame_count_reg <= cfg_wr_data;
            end
            if (cmd.clear_wr) begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_tuser;
            frame_reg <= s_tdata[11:0];
            kern_reg  <= s_tdata[12];
            wr_reg    <= s_tdata[13];
        end
        if (cmd.scan_start) begin
            scan_idx_reg <= '0;
        end else if (cmd.scan_next) begin
            scan_idx_reg <= scan_nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_frame_reg <= '0;
            res_pres_reg  <= 1'b0;
            res_wr_reg    <= 1'b0;
            res_user_reg  <= 1'b0;
            res_stat_reg  <= STAT_DONE;
            res_used_reg  <= 1'b0;
            case (cmd.res_kind)
                RES_HAD_FRAME: begin
                    res_frame_reg <= frame_reg;
                    res_stat_reg  <= STAT_HAD_FRAME;
                end
                RES_NO_FREE: begin
                    res_stat_reg <= STAT_NO_FREE;
                end
                RES_NOTHING: begin
                    res_stat_reg <= STAT_NOTHING;
                end
                RES_ALLOC: begin
                    res_frame_reg <= {scan_idx_reg[6:0], free_pos};
                    res_pres_reg  <= 1'b1;
                    res_wr_reg    <= wr_reg;
                    res_user_reg  <= ~kern_reg;
                end
                RES_TEST: begin
                    res_frame_reg <= frame_reg;
                    res_used_reg  <= rdata[frame_reg[4:0]];
                end
                RES_TEST_MISS: begin
                    res_frame_reg <= frame_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {res_used_reg, res_user_reg, res_wr_reg, res_pres_reg, res_frame_reg};
            m_tuser_reg <= res_stat_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        stat.clear_last = (clr_idx_reg == LAST_WORD);
        stat.op         = op_reg;
        stat.frame_zero = (frame_reg == '0);
        stat.frame_oob  = ({1'b0, frame_reg} >= FRAME_CAP_V);
        stat.scan_empty = (scan_words == 8'd0);
        stat.word_full  = (rdata == FULL_WORD);
        stat.scan_last  = (scan_nxt >= scan_words);
        stat.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule
